// ----- hdl/bfm_pkg.sv -----
// Package for the Butterworth frequency mask filter.
// Holds the payload structs, stage structs, widths and rounding helpers.
// Has no dependencies; every other file in hdl uses it.
package bfm_pkg;

    localparam int CUT_W     = 11;
    localparam int GRID_W    = 13;
    localparam int COORD_W   = 12;
    localparam int SAMP_W    = 32;
    localparam int WGT_W     = 17;
    localparam int D2_W      = 22;
    localparam int D4_W      = 44;
    localparam int SQ_W      = 24;
    localparam int R2_W      = 25;
    localparam int R4_W      = 50;
    localparam int DEN_W     = 51;
    localparam int NUM_W     = 61;
    localparam int QBITS     = 17;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = SAMP_W + WGT_W;
    localparam int CIDX_W    = 2;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_COLS   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        [COORD_W-1:0] row_index;
        logic        [COORD_W-1:0] col_index;
        logic signed [SAMP_W-1:0]  sample_real;
        logic signed [SAMP_W-1:0]  sample_imag;
    } in_t;

    typedef struct packed {
        logic        [WGT_W-1:0]  low_weight;
        logic        [WGT_W-1:0]  high_weight;
        logic signed [SAMP_W-1:0] low_real;
        logic signed [SAMP_W-1:0] low_imag;
        logic signed [SAMP_W-1:0] high_real;
        logic signed [SAMP_W-1:0] high_imag;
    } out_t;

    typedef struct packed {
        logic [CUT_W-1:0]   cutoff;
        logic [COORD_W-1:0] row_ctr;
        logic [COORD_W-1:0] col_ctr;
    } geom_cfg_t;

    typedef struct packed {
        logic                     zero;
        logic [DEN_W-1:0]         den;
        logic [NUM_W-1:0]         num;
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
    } div_req_t;

    typedef struct packed {
        logic                     zero;
        logic [DEN_W-1:0]         den;
        logic [DEN_W-1:0]         rem;
        logic [QBITS-1:0]         nlo;
        logic [QBITS-1:0]         q;
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
    } div_stage_t;

    typedef struct packed {
        logic                     zero;
        logic [QBITS-1:0]         q;
        logic signed [SAMP_W-1:0] re;
        logic signed [SAMP_W-1:0] im;
    } div_rsp_t;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Rounds a weighted magnitude half away from zero and saturates to 32 bits.
    // The product never reaches 2^48, so the rounded magnitude fits 33 bits.
    function automatic logic [SAMP_W-1:0] round_sat(input logic [PROD_W-1:0] prod,
                                                    input logic              neg);
        logic [PROD_W:0]   sum;
        logic [SAMP_W:0]   mag;
        logic [SAMP_W-1:0] res;
        sum = {1'b0, prod} + (PROD_W+1)'(32768);
        mag = sum[SAMP_W+FRAC_BITS:FRAC_BITS];
        if (neg) begin
            if (mag > (SAMP_W+1)'(33'h080000000)) begin
                mag = (SAMP_W+1)'(33'h080000000);
            end
            res = ~mag[SAMP_W-1:0] + 32'd1;
        end else begin
            if (mag > (SAMP_W+1)'(33'h07FFFFFFF)) begin
                mag = (SAMP_W+1)'(33'h07FFFFFFF);
            end
            res = mag[SAMP_W-1:0];
        end
        round_sat = res;
    endfunction

endpackage

// ----- hdl/bfm_geom.sv -----
// Geometry front end: distance to the grid centre, r^4, D^4, and the
// numerator and denominator of the low-pass weight. Six register stages.
// Depends on bfm_pkg.
module bfm_geom #(
    parameter int COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfm_pkg::geom_cfg_t   cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bfm_pkg::in_t         in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bfm_pkg::div_req_t    out_data
);

    localparam logic [bfm_pkg::COORD_W-1:0] CMASK = (COORD_BITS >= bfm_pkg::COORD_W)
        ? {bfm_pkg::COORD_W{1'b1}}
        : bfm_pkg::COORD_W'((1 << COORD_BITS) - 1);

    logic [6:1] v_reg;
    logic [7:1] rdy;

    logic [bfm_pkg::COORD_W-1:0] dr_reg, dc_reg;
    logic [bfm_pkg::D2_W-1:0]    d2_reg;
    logic [bfm_pkg::SQ_W-1:0]    dr2_reg, dc2_reg;
    logic [bfm_pkg::D4_W-1:0]    d4a_reg, d4b_reg, d4c_reg, d4d_reg;
    logic [bfm_pkg::R2_W-1:0]    r2_reg;
    logic [bfm_pkg::R4_W-1:0]    r4_reg;
    logic [bfm_pkg::DEN_W-1:0]   den5_reg, den6_reg;
    logic [bfm_pkg::NUM_W-1:0]   num_reg;
    logic                        zero4_reg, zero5_reg, zero6_reg;
    logic signed [bfm_pkg::SAMP_W-1:0] re_reg [6:1];
    logic signed [bfm_pkg::SAMP_W-1:0] im_reg [6:1];

    logic [bfm_pkg::COORD_W-1:0] row_next, col_next;

    assign rdy[7] = out_ready;
    genvar k;
    generate
        for (k = 1; k <= 6; k++) begin : g_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate
    assign in_ready  = rdy[1];
    assign out_valid = v_reg[6];

    assign row_next = in_data.row_index & CMASK;
    assign col_next = in_data.col_index & CMASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) v_reg[1] <= in_valid;
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
            if (rdy[5]) v_reg[5] <= v_reg[4];
            if (rdy[6]) v_reg[6] <= v_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1]) begin
            dr_reg    <= bfm_pkg::abs_diff(row_next, cfg.row_ctr);
            dc_reg    <= bfm_pkg::abs_diff(col_next, cfg.col_ctr);
            d2_reg    <= bfm_pkg::D2_W'(cfg.cutoff) * bfm_pkg::D2_W'(cfg.cutoff);
            re_reg[1] <= in_data.sample_real;
            im_reg[1] <= in_data.sample_imag;
        end
        if (rdy[2]) begin
            dr2_reg   <= bfm_pkg::SQ_W'(dr_reg) * bfm_pkg::SQ_W'(dr_reg);
            dc2_reg   <= bfm_pkg::SQ_W'(dc_reg) * bfm_pkg::SQ_W'(dc_reg);
            d4a_reg   <= bfm_pkg::D4_W'(d2_reg) * bfm_pkg::D4_W'(d2_reg);
            re_reg[2] <= re_reg[1];
            im_reg[2] <= im_reg[1];
        end
        if (rdy[3]) begin
            r2_reg    <= bfm_pkg::R2_W'(dr2_reg) + bfm_pkg::R2_W'(dc2_reg);
            d4b_reg   <= d4a_reg;
            re_reg[3] <= re_reg[2];
            im_reg[3] <= im_reg[2];
        end
        if (rdy[4]) begin
            r4_reg    <= bfm_pkg::R4_W'(r2_reg) * bfm_pkg::R4_W'(r2_reg);
            zero4_reg <= (r2_reg == '0);
            d4c_reg   <= d4b_reg;
            re_reg[4] <= re_reg[3];
            im_reg[4] <= im_reg[3];
        end
        if (rdy[5]) begin
            den5_reg  <= bfm_pkg::DEN_W'(d4c_reg) + bfm_pkg::DEN_W'(r4_reg);
            zero5_reg <= zero4_reg;
            d4d_reg   <= d4c_reg;
            re_reg[5] <= re_reg[4];
            im_reg[5] <= im_reg[4];
        end
        if (rdy[6]) begin
            // The half-denominator term rounds the quotient to nearest.
            num_reg   <= bfm_pkg::NUM_W'({d4d_reg, {bfm_pkg::FRAC_BITS{1'b0}}})
                         + bfm_pkg::NUM_W'(den5_reg[bfm_pkg::DEN_W-1:1]);
            den6_reg  <= den5_reg;
            zero6_reg <= zero5_reg;
            re_reg[6] <= re_reg[5];
            im_reg[6] <= im_reg[5];
        end
    end

    always_comb
    begin
        out_data.zero = zero6_reg;
        out_data.den  = den6_reg;
        out_data.num  = num_reg;
        out_data.re   = re_reg[6];
        out_data.im   = im_reg[6];
    end

endmodule

// ----- hdl/bfm_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Produces the 17-bit low-pass weight quotient. Depends on bfm_pkg.
module bfm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfm_pkg::div_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfm_pkg::div_rsp_t  out_data
);

    localparam int N = bfm_pkg::QBITS;

    logic                  v_reg   [N];
    logic                  rdy     [N+1];
    bfm_pkg::div_stage_t   st_reg  [N];
    bfm_pkg::div_stage_t   src     [N];
    bfm_pkg::div_stage_t   st_next [N];

    // The numerator is below den * 2^17, so its top bits start the remainder.
    always_comb
    begin
        src[0].zero = in_data.zero;
        src[0].den  = in_data.den;
        src[0].rem  = bfm_pkg::DEN_W'(in_data.num[bfm_pkg::NUM_W-1:N]);
        src[0].nlo  = in_data.num[N-1:0];
        src[0].q    = '0;
        src[0].re   = in_data.re;
        src[0].im   = in_data.im;
    end

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            localparam int BIT = N - 1 - k;
            logic [bfm_pkg::DEN_W:0]   trial;
            logic [bfm_pkg::DEN_W+1:0] diff;

            if (k > 0) begin : g_link
                assign src[k] = st_reg[k-1];
            end

            assign rdy[k] = !v_reg[k] || rdy[k+1];

            always_comb
            begin
                trial      = {src[k].rem, src[k].nlo[BIT]};
                diff       = {1'b0, trial} - {2'b00, src[k].den};
                st_next[k] = src[k];
                if (!diff[bfm_pkg::DEN_W+1]) begin
                    st_next[k].rem    = diff[bfm_pkg::DEN_W-1:0];
                    st_next[k].q[BIT] = 1'b1;
                end else begin
                    st_next[k].rem    = trial[bfm_pkg::DEN_W-1:0];
                    st_next[k].q[BIT] = 1'b0;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    v_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    if (k == 0) begin
                        v_reg[k] <= in_valid;
                    end else begin
                        v_reg[k] <= v_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k]) begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_data.zero = st_reg[N-1].zero;
        out_data.q    = st_reg[N-1].q;
        out_data.re   = st_reg[N-1].re;
        out_data.im   = st_reg[N-1].im;
    end

endmodule

// ----- hdl/bfm_scale.sv -----
// Weight selection and sample scaling: picks the low and high weights,
// multiplies both sample parts by each, then rounds and saturates.
// Three register stages, the last is the output register. Depends on bfm_pkg.
module bfm_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfm_pkg::div_rsp_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfm_pkg::out_t      out_data
);

    logic [3:1] v_reg;
    logic [4:1] rdy;

    logic [bfm_pkg::WGT_W-1:0]  lw_a_reg, hw_a_reg, lw_b_reg, hw_b_reg;
    logic [bfm_pkg::SAMP_W-1:0] mre_reg, mim_reg;
    logic                       nre_a_reg, nim_a_reg, nre_b_reg, nim_b_reg;
    logic [bfm_pkg::PROD_W-1:0] plr_reg, pli_reg, phr_reg, phi_reg;
    bfm_pkg::out_t              out_reg;

    logic [bfm_pkg::WGT_W-1:0]  lw_next;

    assign rdy[4] = out_ready;
    genvar k;
    generate
        for (k = 1; k <= 3; k++) begin : g_rdy
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    endgenerate
    assign in_ready  = rdy[1];
    assign out_valid = v_reg[3];
    assign out_data  = out_reg;

    // At the grid centre the weight is exactly one.
    assign lw_next = in_data.zero ? bfm_pkg::ONE_Q16 : in_data.q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else begin
            if (rdy[1]) v_reg[1] <= in_valid;
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1]) begin
            lw_a_reg  <= lw_next;
            hw_a_reg  <= bfm_pkg::ONE_Q16 - lw_next;
            nre_a_reg <= in_data.re[bfm_pkg::SAMP_W-1];
            nim_a_reg <= in_data.im[bfm_pkg::SAMP_W-1];
            mre_reg   <= in_data.re[bfm_pkg::SAMP_W-1] ? -in_data.re : in_data.re;
            mim_reg   <= in_data.im[bfm_pkg::SAMP_W-1] ? -in_data.im : in_data.im;
        end
        if (rdy[2]) begin
            plr_reg   <= bfm_pkg::PROD_W'(mre_reg) * bfm_pkg::PROD_W'(lw_a_reg);
            pli_reg   <= bfm_pkg::PROD_W'(mim_reg) * bfm_pkg::PROD_W'(lw_a_reg);
            phr_reg   <= bfm_pkg::PROD_W'(mre_reg) * bfm_pkg::PROD_W'(hw_a_reg);
            phi_reg   <= bfm_pkg::PROD_W'(mim_reg) * bfm_pkg::PROD_W'(hw_a_reg);
            lw_b_reg  <= lw_a_reg;
            hw_b_reg  <= hw_a_reg;
            nre_b_reg <= nre_a_reg;
            nim_b_reg <= nim_a_reg;
        end
        if (rdy[3]) begin
            out_reg.low_weight  <= lw_b_reg;
            out_reg.high_weight <= hw_b_reg;
            out_reg.low_real    <= bfm_pkg::round_sat(plr_reg, nre_b_reg);
            out_reg.low_imag    <= bfm_pkg::round_sat(pli_reg, nim_b_reg);
            out_reg.high_real   <= bfm_pkg::round_sat(phr_reg, nre_b_reg);
            out_reg.high_imag   <= bfm_pkg::round_sat(phi_reg, nim_b_reg);
        end
    end

endmodule

// ----- hdl/butterworth_freq_mask_filter_top.sv -----
// Top level of the second-order Butterworth frequency mask filter.
// Instantiates bfm_geom, bfm_div and bfm_scale; depends on bfm_pkg.
//
// Each request carries one complex spectrum sample with its row and column.
// The block forms the squared distance r2 from the grid centre
// (grid_rows/2, grid_cols/2), computes the low-pass weight
// D^4 / (D^4 + r2^2) in unsigned Q1.16 rounded to nearest, the high-pass
// weight as its complement, and returns both weights together with the
// sample scaled by each weight (rounded half away from zero, saturated to
// 32 bits). A request is accepted every clock cycle while out_ready does not
// hold the output back. The pipeline is the 17-stage long divider, one quotient
// bit per stage, behind six stages of distance and power arithmetic and ahead
// of three stages of weighting.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled output loses
// nothing. The three configuration registers (index 0 cutoff radius, 1 grid
// rows, 2 grid columns) are always ready; writes to other indexes are
// ignored, and they should be written only while no request is in flight.
module butterworth_freq_mask_filter_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfm_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [bfm_pkg::GRID_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bfm_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bfm_pkg::out_t                 out_data
);

    logic [bfm_pkg::CUT_W-1:0]  cutoff_reg;
    logic [bfm_pkg::GRID_W-1:0] rows_reg;
    logic [bfm_pkg::GRID_W-1:0] cols_reg;

    bfm_pkg::geom_cfg_t geom_cfg;

    logic              req_valid, req_ready;
    bfm_pkg::div_req_t req_data;
    logic              rsp_valid, rsp_ready;
    bfm_pkg::div_rsp_t rsp_data;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes fall through to the default arm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cutoff_reg <= bfm_pkg::CUT_W'(30);
            rows_reg   <= bfm_pkg::GRID_W'(512);
            cols_reg   <= bfm_pkg::GRID_W'(512);
        end else if (cfg_valid) begin
            case (cfg_index)
                bfm_pkg::CFG_CUTOFF: cutoff_reg <= cfg_data[bfm_pkg::CUT_W-1:0];
                bfm_pkg::CFG_ROWS:   rows_reg   <= cfg_data;
                bfm_pkg::CFG_COLS:   cols_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // The centre is half the grid size, rounded down.
    always_comb
    begin
        geom_cfg.cutoff  = cutoff_reg;
        geom_cfg.row_ctr = rows_reg[bfm_pkg::GRID_W-1:1];
        geom_cfg.col_ctr = cols_reg[bfm_pkg::GRID_W-1:1];
    end

    bfm_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (geom_cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (req_valid),
        .out_ready (req_ready),
        .out_data  (req_data)
    );

    bfm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .in_data   (req_data),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp_data)
    );

    bfm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rsp_valid),
        .in_ready  (rsp_ready),
        .in_data   (rsp_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
